>>> design/pia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pia_pkg
// Shared types and constants for the primitive index assembler.
// ----------------------------------------------------------------------------
package pia_pkg;

   localparam int DEFAULT_VERTEX_STORE_DEPTH = 65536;

   localparam int POS_W        = 16;  // position within a draw
   localparam int OUT_IDX_W    = 16;  // index width on the result word
   localparam int MAX_TRIS     = 4;   // most triangles one vertex completes
   localparam int TRI_CNT_W    = 3;   // holds 0..MAX_TRIS
   localparam int REQ_TDATA_W  = 8;
   localparam int REQ_TUSER_W  = 3;
   localparam int RSP_TDATA_W  = 3 * OUT_IDX_W;

   typedef enum logic {
      OP_VERTEX = 1'b0,
      OP_CLEAR  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      MODE_TRIANGLES      = 3'd0,
      MODE_QUADS          = 3'd1,
      MODE_QUAD_STRIP     = 3'd2,
      MODE_FAN            = 3'd3,
      MODE_STRIP          = 3'd4,
      MODE_SYM_QUAD_STRIP = 3'd5
   } mode_type;

   // position of the arriving vertex, with its residue mod 3 kept alongside
   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [1:0]       mod3;
   } pos_info_type;

endpackage

>>> design/pia_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pia_state
// Draw counters: store count, draw base, position and current store index.
// ----------------------------------------------------------------------------
module pia_state
   import pia_pkg::*;
#(
   parameter int VERTEX_STORE_DEPTH = DEFAULT_VERTEX_STORE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  vertex_step,
   input  logic                                  clear_step,
   input  logic                                  last_vertex,
   output logic [$clog2(VERTEX_STORE_DEPTH)-1:0] cur_index,
   output logic [$clog2(VERTEX_STORE_DEPTH)-1:0] base_index,
   output pos_info_type                          pos_info
);

   localparam int IDX_W = $clog2(VERTEX_STORE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(VERTEX_STORE_DEPTH - 1);

   logic [IDX_W-1:0] store_ff, store_in;
   logic [IDX_W-1:0] base_ff, base_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [1:0]       mod3_ff, mod3_in;
   logic [IDX_W-1:0] store_next;
   logic [IDX_W-1:0] cur_next;

   assign store_next = (store_ff == IDX_TOP) ? '0 : store_ff + 1'b1;
   assign cur_next   = (cur_ff == IDX_TOP) ? '0 : cur_ff + 1'b1;

   always_comb begin
      store_in = store_ff;
      base_in  = base_ff;
      cur_in   = cur_ff;
      pos_in   = pos_ff;
      mod3_in  = mod3_ff;
      if (clear_step) begin
         store_in = '0;
         base_in  = '0;
         cur_in   = '0;
         pos_in   = '0;
         mod3_in  = '0;
      end else if (vertex_step) begin
         store_in = store_next;
         if (last_vertex) begin
            base_in = store_next;
            cur_in  = store_next;
            pos_in  = '0;
            mod3_in = '0;
         end else if (pos_ff == {POS_W{1'b1}}) begin
            // position wraps inside a long draw: back to vertex 0
            cur_in  = base_ff;
            pos_in  = '0;
            mod3_in = '0;
         end else begin
            cur_in  = cur_next;
            pos_in  = pos_ff + 1'b1;
            mod3_in = (mod3_ff == 2'd2) ? 2'd0 : mod3_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         base_ff  <= '0;
         cur_ff   <= '0;
         pos_ff   <= '0;
         mod3_ff  <= '0;
      end else begin
         store_ff <= store_in;
         base_ff  <= base_in;
         cur_ff   <= cur_in;
         pos_ff   <= pos_in;
         mod3_ff  <= mod3_in;
      end
   end

   assign cur_index         = cur_ff;
   assign base_index        = base_ff;
   assign pos_info.position = pos_ff;
   assign pos_info.mod3     = mod3_ff;

   // clear brings every counter back to zero
   assert property (@(posedge clock) disable iff (reset)
      clear_step |=> (store_ff == '0 && base_ff == '0 && cur_ff == '0 &&
                      pos_ff == '0 && mod3_ff == '0))
      else $error("pia_state: counters not cleared");

   // at position zero the current index is the draw base
   assert property (@(posedge clock) disable iff (reset)
      (pos_ff == '0) |-> (cur_ff == base_ff))
      else $error("pia_state: current index off the draw base");

endmodule

>>> design/pia_tri_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pia_tri_gen
// Decodes mode and position into the triangles a vertex completes.
// ----------------------------------------------------------------------------
module pia_tri_gen
   import pia_pkg::*;
#(
   parameter int VERTEX_STORE_DEPTH = DEFAULT_VERTEX_STORE_DEPTH
) (
   input  logic [2:0]                                  mode,
   input  pos_info_type                                pos_info,
   input  logic [$clog2(VERTEX_STORE_DEPTH)-1:0]       cur_index,
   input  logic [$clog2(VERTEX_STORE_DEPTH)-1:0]       base_index,
   output logic [TRI_CNT_W-1:0]                        tri_count,
   output logic [MAX_TRIS-1:0][2:0][$clog2(VERTEX_STORE_DEPTH)-1:0] tris
);

   localparam int IDX_W  = $clog2(VERTEX_STORE_DEPTH);
   localparam int BACK_N = 6;

   typedef logic [2:0][IDX_W-1:0] tri_type;

   // store index k vertices back from the current one, modulo depth
   function automatic logic [IDX_W-1:0] back_idx(input logic [IDX_W-1:0] x,
                                                 input logic [2:0] k);
      logic [IDX_W:0] wide;
      begin
         if ({1'b0, x} >= (IDX_W+1)'(k))
            wide = {1'b0, x} - (IDX_W+1)'(k);
         else
            wide = {1'b0, x} + (IDX_W+1)'(VERTEX_STORE_DEPTH) - (IDX_W+1)'(k);
         back_idx = wide[IDX_W-1:0];
      end
   endfunction

   function automatic tri_type mk(input logic [IDX_W-1:0] a,
                                  input logic [IDX_W-1:0] b,
                                  input logic [IDX_W-1:0] c);
      tri_type t;
      begin
         t[0] = a;
         t[1] = b;
         t[2] = c;
         mk   = t;
      end
   endfunction

   logic [BACK_N-1:0][IDX_W-1:0] bk;
   logic [POS_W-1:0]             p;

   assign p = pos_info.position;

   always_comb begin
      for (int k = 0; k < BACK_N; k++) begin
         bk[k] = back_idx(cur_index, 3'(k));
      end
   end

   always_comb begin
      tri_count = '0;
      tris      = '0;
      case (mode_type'(mode))
         MODE_TRIANGLES: begin
            if (pos_info.mod3 == 2'd2) begin
               tri_count = 3'd1;
               tris[0]   = mk(bk[2], bk[1], bk[0]);
            end
         end
         MODE_QUADS: begin
            if (p[1:0] == 2'b11) begin
               tri_count = 3'd2;
               tris[0]   = mk(bk[3], bk[2], bk[1]);
               tris[1]   = mk(bk[1], bk[0], bk[3]);
            end
         end
         MODE_QUAD_STRIP: begin
            if (p[0] && p >= POS_W'(3)) begin
               tri_count = 3'd2;
               tris[0]   = mk(bk[3], bk[2], bk[1]);
               tris[1]   = mk(bk[2], bk[1], bk[0]);
            end
         end
         MODE_FAN: begin
            if (p >= POS_W'(2)) begin
               tri_count = 3'd1;
               tris[0]   = mk(base_index, bk[1], bk[0]);
            end
         end
         MODE_STRIP: begin
            // winding flips on odd triangles
            if (p >= POS_W'(2)) begin
               tri_count = 3'd1;
               if (!p[0])
                  tris[0] = mk(bk[2], bk[1], bk[0]);
               else
                  tris[0] = mk(bk[1], bk[2], bk[0]);
            end
         end
         MODE_SYM_QUAD_STRIP: begin
            // four triangles around the shared vertex four back
            if (pos_info.mod3 == 2'd2 && p >= POS_W'(5)) begin
               tri_count = 3'd4;
               tris[0]   = mk(bk[2], bk[4], bk[5]);
               tris[1]   = mk(bk[1], bk[4], bk[2]);
               tris[2]   = mk(bk[0], bk[4], bk[1]);
               tris[3]   = mk(bk[3], bk[4], bk[0]);
            end
         end
         default: begin
            tri_count = '0;
         end
      endcase
   end

endmodule

>>> design/pia_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pia_emitter
// Holds one vertex's triangle list; hands out a word per cycle when not stalled.
// ----------------------------------------------------------------------------
module pia_emitter
   import pia_pkg::*;
#(
   parameter int VERTEX_STORE_DEPTH = DEFAULT_VERTEX_STORE_DEPTH
) (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  logic                                                    load_job,
   input  logic [TRI_CNT_W-1:0]                                    tri_count,
   input  logic [MAX_TRIS-1:0][2:0][$clog2(VERTEX_STORE_DEPTH)-1:0] tris,
   output logic                                                    take_ready,
   output logic                                                    rsp_tvalid,
   input  logic                                                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]                                  rsp_tdata,
   output logic                                                    rsp_tlast
);

   localparam int IDX_W  = $clog2(VERTEX_STORE_DEPTH);
   localparam int SLOT_W = $clog2(MAX_TRIS);

   logic                                   job_valid_ff, job_valid_in;
   logic [TRI_CNT_W-1:0]                   job_cnt_ff, job_cnt_in;
   logic [SLOT_W-1:0]                      job_slot_ff, job_slot_in;
   logic [MAX_TRIS-1:0][2:0][IDX_W-1:0]    job_tris_ff, job_tris_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]                 rsp_data_ff, rsp_data_in;
   logic                                   rsp_last_ff, rsp_last_in;

   logic out_load;
   logic slot_last;
   logic drain_last;
   logic start_job;

   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign slot_last  = (TRI_CNT_W'(job_slot_ff) + 1'b1) == job_cnt_ff;
   assign drain_last = job_valid_ff && out_load && slot_last;
   assign take_ready = !job_valid_ff || drain_last;
   assign start_job  = load_job && (tri_count != '0);

   always_comb begin
      job_valid_in = job_valid_ff;
      job_cnt_in   = job_cnt_ff;
      job_slot_in  = job_slot_ff;
      job_tris_in  = job_tris_ff;
      if (start_job) begin
         job_valid_in = 1'b1;
         job_cnt_in   = tri_count;
         job_slot_in  = '0;
         job_tris_in  = tris;
      end else if (drain_last) begin
         job_valid_in = 1'b0;
      end else if (job_valid_ff && out_load) begin
         job_slot_in = job_slot_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = job_valid_ff;
         rsp_data_in  = {OUT_IDX_W'(job_tris_ff[job_slot_ff][2]),
                         OUT_IDX_W'(job_tris_ff[job_slot_ff][1]),
                         OUT_IDX_W'(job_tris_ff[job_slot_ff][0])};
         rsp_last_in  = slot_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         job_cnt_ff   <= '0;
         job_slot_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         job_cnt_ff   <= job_cnt_in;
         job_slot_ff  <= job_slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_tris_ff <= job_tris_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a held job always points at a slot inside its list
   assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> (job_cnt_ff != '0 && job_cnt_ff <= TRI_CNT_W'(MAX_TRIS) &&
                        TRI_CNT_W'(job_slot_ff) < job_cnt_ff))
      else $error("pia_emitter: slot outside job");

endmodule

>>> design/primitive_index_assembler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// primitive_index_assembler_core
// Turns a stream of tagged vertices into triangle index words.
// ----------------------------------------------------------------------------
// Each request word is one vertex (or a clear) tagged with its draw mode;
// tlast marks the draw's final vertex. The block tracks the store count,
// the draw base and the position within the draw, and for every vertex that
// completes triangles it sends one response word per triangle: three store
// indices modulo VERTEX_STORE_DEPTH, with tlast on the last triangle that
// vertex caused. Its triangles are decoded at once into a job register, and
// the result register then hands out one word per cycle while rsp_tready
// allows, n words for n triangles (n at most four). A new vertex is taken
// in the same cycle as the previous job's last word moves to the result
// register. Unknown modes count the vertex and emit nothing. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module primitive_index_assembler_core
   import pia_pkg::*;
#(
   parameter int VERTEX_STORE_DEPTH = DEFAULT_VERTEX_STORE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [0] op, rest zero
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // [2:0] mode
   input  logic                   req_tlast,   // last_vertex
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [15:0] first_index,
                                               // [31:16] second_index,
                                               // [47:32] third_index
   output logic                   rsp_tlast    // last_of_run
);

   localparam int IDX_W = $clog2(VERTEX_STORE_DEPTH);

   logic                                req_accept;
   logic                                vertex_step;
   logic                                clear_step;
   logic [IDX_W-1:0]                    cur_index;
   logic [IDX_W-1:0]                    base_index;
   pos_info_type                        pos_info;
   logic [TRI_CNT_W-1:0]                tri_count;
   logic [MAX_TRIS-1:0][2:0][IDX_W-1:0] tris;
   logic                                take_ready;

   // a word moves when both sides agree
   assign req_accept  = req_tvalid && req_tready;
   assign vertex_step = req_accept && (op_type'(req_tdata[0]) == OP_VERTEX);
   assign clear_step  = req_accept && (op_type'(req_tdata[0]) == OP_CLEAR);
   assign req_tready  = take_ready;

   // counters; updated the cycle a word is taken
   pia_state #(
      .VERTEX_STORE_DEPTH (VERTEX_STORE_DEPTH)
   ) u_state (
      .clock       (clock),
      .reset       (reset),
      .vertex_step (vertex_step),
      .clear_step  (clear_step),
      .last_vertex (req_tlast),
      .cur_index   (cur_index),
      .base_index  (base_index),
      .pos_info    (pos_info)
   );

   // triangle decode straight from the incoming word and current counters
   pia_tri_gen #(
      .VERTEX_STORE_DEPTH (VERTEX_STORE_DEPTH)
   ) u_tri_gen (
      .mode       (req_tuser),
      .pos_info   (pos_info),
      .cur_index  (cur_index),
      .base_index (base_index),
      .tri_count  (tri_count),
      .tris       (tris)
   );

   // job register and result register
   pia_emitter #(
      .VERTEX_STORE_DEPTH (VERTEX_STORE_DEPTH)
   ) u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load_job   (vertex_step),
      .tri_count  (tri_count),
      .tris       (tris),
      .take_ready (take_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // triangles of one vertex follow each other without a gap
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("primitive_index_assembler_core: gap inside a run");

endmodule
